@@ sv/swept_circle_circle_impact_macros.svh @@
// Assertion macros for the swept circle-circle impact block.
// Used by the top level only; depends on nothing.
`ifndef SWEPT_CIRCLE_CIRCLE_IMPACT_MACROS_SVH
`define SWEPT_CIRCLE_CIRCLE_IMPACT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge out of reset.
`define SCI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sci assertion failed");
// Next-cycle implication.
`define SCI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sci assertion failed");
`else
`define SCI_ASSERT_NOW(label, ante, cons)
`define SCI_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ sv/sci_pkg.sv @@
// Shared types and constants for the swept circle-circle impact block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package sci_pkg;

  localparam int TIME_W = 18;
  localparam logic [TIME_W-1:0] TIME_ONE  = 18'd65536;
  localparam logic [TIME_W-1:0] TIME_NONE = 18'd131072;
  localparam int SEARCH_BITS = 17;
  localparam int Q_W   = 70;
  localparam int HALF_W = 35;
  localparam int F_W   = 110;

  typedef struct packed {
    logic signed [31:0] a_start_x;
    logic signed [31:0] a_start_y;
    logic signed [31:0] a_end_x;
    logic signed [31:0] a_end_y;
    logic signed [31:0] b_start_x;
    logic signed [31:0] b_start_y;
    logic signed [31:0] b_end_x;
    logic signed [31:0] b_end_y;
    logic [30:0]        radius_a;
    logic [30:0]        radius_b;
  } sci_in_t;

  typedef struct packed {
    logic              hit;
    logic [TIME_W-1:0] impact_time;
  } sci_out_t;

  // State handed from cell to cell along the search chain.
  typedef struct packed {
    logic                   valid;
    logic                   found;
    logic                   upper;
    logic                   f1_zero;
    logic [TIME_W-1:0]      lo;
    logic signed [Q_W-1:0]  qa;
    logic signed [F_W-1:0]  f;
    logic signed [F_W-1:0]  g;
  } sci_cell_t;

endpackage

@@ sv/sci_front.sv @@
// Front pipeline: motion vectors, quadratic coefficients, discriminant and
// root choice. Depends on sci_pkg; feeds the first search cell.
`timescale 1ns / 1ps
module sci_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  sci_pkg::sci_in_t     in_req,
  output sci_pkg::sci_cell_t   cell_out
);

  localparam int QW = sci_pkg::Q_W;
  localparam int HW = sci_pkg::HALF_W;
  localparam int FW = sci_pkg::F_W;
  localparam int PW = 2 * QW;

  // Stage 1: offsets and relative motion
  logic               s1_valid_r;
  logic signed [32:0] s1_ax_r, s1_ay_r;
  logic signed [33:0] s1_bx_r, s1_by_r;
  logic        [31:0] s1_rsum_r;
  logic signed [31:0] s1_rdiff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ax_r <= 33'(in_req.a_start_x) - 33'(in_req.b_start_x);
      s1_ay_r <= 33'(in_req.a_start_y) - 33'(in_req.b_start_y);
      s1_bx_r <= 34'(in_req.a_end_x) - 34'(in_req.a_start_x)
               - 34'(in_req.b_end_x) + 34'(in_req.b_start_x);
      s1_by_r <= 34'(in_req.a_end_y) - 34'(in_req.a_start_y)
               - 34'(in_req.b_end_y) + 34'(in_req.b_start_y);
      s1_rsum_r  <= {1'b0, in_req.radius_a} + {1'b0, in_req.radius_b};
      s1_rdiff_r <= $signed({1'b0, in_req.radius_a}) - $signed({1'b0, in_req.radius_b});
    end
  end

  // Stage 2: squares and dot products
  logic                  s2_valid_r;
  logic signed [QW-1:0]  s2_axx_r, s2_ayy_r, s2_bxx_r, s2_byy_r;
  logic signed [QW-1:0]  s2_axbx_r, s2_ayby_r, s2_rsum2_r, s2_rdiff2_r;
  logic signed [QW-1:0]  rsum_s;

  assign rsum_s = QW'($signed({1'b0, s1_rsum_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_axx_r    <= QW'(s1_ax_r) * QW'(s1_ax_r);
      s2_ayy_r    <= QW'(s1_ay_r) * QW'(s1_ay_r);
      s2_bxx_r    <= QW'(s1_bx_r) * QW'(s1_bx_r);
      s2_byy_r    <= QW'(s1_by_r) * QW'(s1_by_r);
      s2_axbx_r   <= QW'(s1_ax_r) * QW'(s1_bx_r);
      s2_ayby_r   <= QW'(s1_ay_r) * QW'(s1_by_r);
      s2_rsum2_r  <= rsum_s * rsum_s;
      s2_rdiff2_r <= QW'(s1_rdiff_r) * QW'(s1_rdiff_r);
    end
  end

  // Stage 3: coefficients a, h, c of a t^2 + 2 h t + c
  logic                  s3_valid_r;
  logic signed [QW-1:0]  s3_qa_r, s3_qh_r, s3_qc_r;
  logic signed [QW-1:0]  dist2;
  logic                  apart;

  assign dist2 = s2_axx_r + s2_ayy_r;
  assign apart = dist2 >= s2_rsum2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_qa_r <= s2_bxx_r + s2_byy_r;
      s3_qh_r <= s2_axbx_r + s2_ayby_r;
      s3_qc_r <= dist2 - (apart ? s2_rsum2_r : s2_rdiff2_r);
    end
  end

  // Stage 4: discriminant partial products and end-point tests
  logic [QW-1:0] h_mag, a_mag, c_mag;
  logic signed [FW-1:0] a_w, h_w, c_w, vert_n, f_n, f_1;
  logic l0, ln, u0, un;

  assign h_mag = s3_qh_r[QW-1] ? QW'(-s3_qh_r) : QW'(s3_qh_r);
  assign a_mag = s3_qa_r;
  assign c_mag = s3_qc_r;
  assign a_w = FW'(s3_qa_r);
  assign h_w = FW'(s3_qh_r);
  assign c_w = FW'(s3_qc_r);
  assign vert_n = (a_w <<< 17) + (h_w <<< 16);
  assign f_n    = (a_w <<< 34) + (h_w <<< 34) + (c_w <<< 32);
  assign f_1    = (a_w <<< 32) + (h_w <<< 33) + (c_w <<< 32);
  // Lower and upper root tests at t = 0 and t = 2
  assign l0 = (s3_qh_r <= 0) && (s3_qc_r >= 0);
  assign ln = (vert_n <= 0) && (f_n >= 0);
  assign u0 = (s3_qh_r <= 0) || (s3_qc_r <= 0);
  assign un = (vert_n <= 0) || (f_n <= 0);

  logic                 s4_valid_r;
  logic [QW-1:0]        s4_hh_r, s4_hl_r, s4_ll_r;
  logic [QW-1:0]        s4_ahch_r, s4_ahcl_r, s4_alch_r, s4_alcl_r;
  logic                 s4_root0_r, s4_root1_r, s4_f1z_r, s4_anz_r, s4_cneg_r;
  logic signed [QW-1:0] s4_qa_r, s4_qh_r, s4_qc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_hh_r   <= QW'(h_mag[QW-1:HW]) * QW'(h_mag[QW-1:HW]);
      s4_hl_r   <= QW'(h_mag[QW-1:HW]) * QW'(h_mag[HW-1:0]);
      s4_ll_r   <= QW'(h_mag[HW-1:0])  * QW'(h_mag[HW-1:0]);
      s4_ahch_r <= QW'(a_mag[QW-1:HW]) * QW'(c_mag[QW-1:HW]);
      s4_ahcl_r <= QW'(a_mag[QW-1:HW]) * QW'(c_mag[HW-1:0]);
      s4_alch_r <= QW'(a_mag[HW-1:0])  * QW'(c_mag[QW-1:HW]);
      s4_alcl_r <= QW'(a_mag[HW-1:0])  * QW'(c_mag[HW-1:0]);
      s4_root0_r <= l0 && !ln;
      s4_root1_r <= u0 && !un;
      s4_f1z_r   <= (f_1 == '0);
      s4_anz_r   <= (s3_qa_r != '0);
      s4_cneg_r  <= s3_qc_r[QW-1];
      s4_qa_r <= s3_qa_r;
      s4_qh_r <= s3_qh_r;
      s4_qc_r <= s3_qc_r;
    end
  end

  // Stage 5: discriminant sign and entry into the search chain
  logic [PW-1:0] h2, ac;
  logic          disc_ok;
  sci_pkg::sci_cell_t s5_r;

  assign h2 = (PW'(s4_hh_r) << (2 * HW)) + (PW'(s4_hl_r) << (HW + 1)) + PW'(s4_ll_r);
  assign ac = (PW'(s4_ahch_r) << (2 * HW))
            + ((PW'(s4_ahcl_r) + PW'(s4_alch_r)) << HW) + PW'(s4_alcl_r);
  assign disc_ok = s4_cneg_r || (h2 >= ac);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_r.valid <= 1'b0;
    end else if (en) begin
      s5_r.valid <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_r.found   <= s4_anz_r && disc_ok && (s4_root0_r || s4_root1_r);
      s5_r.upper   <= !s4_root0_r;
      s5_r.f1_zero <= s4_f1z_r;
      s5_r.lo      <= '0;
      s5_r.qa      <= s4_qa_r;
      s5_r.f       <= FW'(s4_qc_r) <<< 32;
      s5_r.g       <= FW'(s4_qh_r) <<< 16;
    end
  end

  assign cell_out = s5_r;

endmodule

@@ sv/sci_cell.sv @@
// One bisection cell: decides one bit of the impact time by shift-and-add
// updates of f(t) and its slope term. Depends on sci_pkg.
`timescale 1ns / 1ps
module sci_cell #(
  parameter int BIT = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  sci_pkg::sci_cell_t cell_in,
  output sci_pkg::sci_cell_t cell_out
);

  localparam int FW = sci_pkg::F_W;

  logic signed [FW-1:0] a_w, vert_mid, f_mid;
  logic left, take;
  sci_pkg::sci_cell_t cell_nxt, cell_r;

  // Evaluate at lo + 2^BIT from the values held at lo
  assign a_w      = FW'(cell_in.qa);
  assign vert_mid = cell_in.g + (a_w <<< BIT);
  assign f_mid    = cell_in.f + (cell_in.g <<< (BIT + 1)) + (a_w <<< (2 * BIT));
  assign left     = vert_mid <= 0;
  assign take     = cell_in.found &&
                    (cell_in.upper ? (left || f_mid <= 0) : (left && f_mid >= 0));

  always_comb begin
    cell_nxt = cell_in;
    if (take) begin
      cell_nxt.lo = cell_in.lo | (sci_pkg::TIME_W'(1) << BIT);
      cell_nxt.f  = f_mid;
      cell_nxt.g  = vert_mid;
    end
  end

  // Advance one cell along the chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r.valid <= cell_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r.found   <= cell_nxt.found;
      cell_r.upper   <= cell_nxt.upper;
      cell_r.f1_zero <= cell_nxt.f1_zero;
      cell_r.lo      <= cell_nxt.lo;
      cell_r.qa      <= cell_nxt.qa;
      cell_r.f       <= cell_nxt.f;
      cell_r.g       <= cell_nxt.g;
    end
  end

  assign cell_out = cell_r;

endmodule

@@ sv/swept_circle_circle_impact.sv @@
// Swept circle-circle time of impact, one request per cycle.
// Pipeline: 5 front stages, 17 bisection cells and 1 output register;
// throughput one request per cycle.
// The whole pipeline holds while a result waits under out_stall.
// Reset (rst_n low, synchronous) drops all requests in flight.
`timescale 1ns / 1ps
`include "swept_circle_circle_impact_macros.svh"
module swept_circle_circle_impact (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sci_pkg::sci_in_t   in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output sci_pkg::sci_out_t  out_req
);

  localparam int NC = sci_pkg::SEARCH_BITS;

  logic en;
  logic out_valid_r;
  sci_pkg::sci_out_t out_req_r, out_nxt;
  sci_pkg::sci_cell_t chain [NC+1];

  // Hold everything while the output waits
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  sci_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_req   (in_req),
    .cell_out (chain[0])
  );

  for (genvar i = 0; i < NC; i++) begin : g_cell
    sci_cell #(.BIT(NC - 1 - i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .cell_in  (chain[i]),
      .cell_out (chain[i+1])
    );
  end

  // Form the result from the last cell
  always_comb begin
    out_nxt.hit         = 1'b0;
    out_nxt.impact_time = sci_pkg::TIME_NONE;
    if (chain[NC].found) begin
      out_nxt.impact_time = chain[NC].lo;
      out_nxt.hit = (chain[NC].lo < sci_pkg::TIME_ONE) ||
                    ((chain[NC].lo == sci_pkg::TIME_ONE) && chain[NC].f1_zero);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= chain[NC].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_req_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

  `SCI_ASSERT_NOW(a_none_no_hit, out_valid_r && (out_req_r.impact_time == sci_pkg::TIME_NONE), !out_req_r.hit)
  `SCI_ASSERT_NOW(a_hit_in_step, out_valid_r && out_req_r.hit, out_req_r.impact_time <= sci_pkg::TIME_ONE)
  `SCI_ASSERT_NOW(a_miss_late, out_valid_r && !out_req_r.hit, out_req_r.impact_time >= sci_pkg::TIME_ONE)
  `SCI_ASSERT_NEXT(a_hold_result, out_valid_r && out_stall, out_valid_r && $stable(out_req_r))

endmodule

@@ verif/tb_swept_circle_circle_impact.sv @@
// Testbench for the swept circle-circle impact block: directed and random requests,
// with an exact wide-integer prediction of impact time and hit flag.
// Depends on sci_pkg and swept_circle_circle_impact.
`timescale 1ns / 1ps
module tb_swept_circle_circle_impact;

  typedef logic signed [159:0] wide_t;

  localparam int UNIT = 65536;
  localparam int IDLE_PCT = 18;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 250;
  localparam int RANDOM_ITEMS = 700;
  localparam int MIN_I = 32'sh8000_0000;
  localparam int MAX_I = 32'sh7fff_ffff;

  // Impact prediction and ordered comparison of results
  class impact_board;
    sci_pkg::sci_out_t pending_q[$];
    int errors;
    int hits;
    int results;

    function wide_t sx(logic [31:0] v);
      return {{128{v[31]}}, v};
    endfunction

    // 2^32 times the quadratic at time q / 2^16
    function wide_t quad_at(wide_t q, wide_t a, wide_t h, wide_t c);
      wide_t s;
      s = UNIT;
      return a * q * q + 2 * h * q * s + c * s * s;
    endfunction

    function bit below_root(wide_t q, bit upper, wide_t a, wide_t h, wide_t c);
      wide_t s;
      wide_t vert;
      wide_t f;
      bit left;
      s = UNIT;
      vert = q * a + h * s;
      left = (vert <= 0);
      f = quad_at(q, a, h, c);
      if (upper) return left || (f <= 0);
      return left && (f >= 0);
    endfunction

    function sci_pkg::sci_out_t impact(sci_pkg::sci_in_t r);
      wide_t ax, ay, bx, by, ra, rb, d2, rs, rw, a, h, c, lo, hi, mid, none;
      int root;
      sci_pkg::sci_out_t o;
      none = sci_pkg::TIME_NONE;
      ax = sx(r.a_start_x) - sx(r.b_start_x);
      ay = sx(r.a_start_y) - sx(r.b_start_y);
      bx = (sx(r.a_end_x) - sx(r.a_start_x)) - (sx(r.b_end_x) - sx(r.b_start_x));
      by = (sx(r.a_end_y) - sx(r.a_start_y)) - (sx(r.b_end_y) - sx(r.b_start_y));
      ra = r.radius_a;
      rb = r.radius_b;
      d2 = ax * ax + ay * ay;
      rs = ra + rb;
      rw = (d2 - rs * rs >= 0) ? rs : ra - rb;
      a = bx * bx + by * by;
      h = ax * bx + ay * by;
      c = d2 - rw * rw;
      o.hit = 1'b0;
      o.impact_time = sci_pkg::TIME_NONE;
      if (a != 0 && h * h - a * c >= 0) begin
        root = -1;
        if (below_root(0, 0, a, h, c) && !below_root(none, 0, a, h, c)) root = 0;
        else if (below_root(0, 1, a, h, c) && !below_root(none, 1, a, h, c)) root = 1;
        if (root >= 0) begin
          lo = 0;
          hi = none;
          while (hi - lo > 1) begin
            mid = (lo + hi) >>> 1;
            if (below_root(mid, root == 1, a, h, c)) lo = mid;
            else hi = mid;
          end
          o.impact_time = lo[sci_pkg::TIME_W-1:0];
          if (lo < UNIT) o.hit = 1'b1;
          else if (lo == UNIT && quad_at(lo, a, h, c) == 0) o.hit = 1'b1;
        end
      end
      return o;
    endfunction

    function void note_request(sci_pkg::sci_in_t r);
      pending_q.insert(pending_q.size(), impact(r));
    endfunction

    function void check_result(sci_pkg::sci_out_t got);
      sci_pkg::sci_out_t want;
      results++;
      if (got.hit) hits++;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result hit=%0b time=%0d", got.hit, got.impact_time);
        return;
      end
      want = pending_q.pop_front();
      if (got.hit !== want.hit || got.impact_time !== want.impact_time) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected hit=%0b time=%0d, got hit=%0b time=%0d",
                   want.hit, want.impact_time, got.hit, got.impact_time);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  sci_pkg::sci_in_t in_req;
  logic out_valid;
  logic out_stall;
  sci_pkg::sci_out_t out_req;

  impact_board board;
  int accepted;
  int idle_cycles;
  bit quiet;

  swept_circle_circle_impact u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_req(out_req)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    out_stall = 1'b0;
    accepted = 0;
    idle_cycles = 0;
    quiet = 1'b0;
  end

  // Note accepted requests, check accepted results, watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        board.note_request(in_req);
        accepted++;
      end
      if (out_valid && !out_stall) board.check_result(out_req);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results pending", board.pending_q.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Receiver: random stalls, one long hold-off once traffic is flowing
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (accepted >= 120 && accepted < 130) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        wait (accepted >= 130);
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  function automatic sci_pkg::sci_in_t mk(int axs, int ays, int axe, int aye, int bxs, int bys,
                                          int bxe, int bye, int unsigned ra, int unsigned rb);
    sci_pkg::sci_in_t r;
    r.a_start_x = axs; r.a_start_y = ays; r.a_end_x = axe; r.a_end_y = aye;
    r.b_start_x = bxs; r.b_start_y = bys; r.b_end_x = bxe; r.b_end_y = bye;
    r.radius_a = ra[30:0];
    r.radius_b = rb[30:0];
    return r;
  endfunction

  function automatic int spread(int unsigned sc);
    return int'($urandom_range(0, 2 * sc)) - int'(sc);
  endfunction

  // Plausible pair: nearby circles with motion on the same scale
  function automatic sci_pkg::sci_in_t random_pair();
    int unsigned sc;
    int bx, by, ox, oy;
    sc = 1 << $urandom_range(4, 28);
    bx = spread(1 << 30);
    by = spread(1 << 30);
    ox = bx + spread(sc);
    oy = by + spread(sc);
    return mk(bx, by, bx + spread(sc), by + spread(sc), ox, oy,
              ox + spread(sc), oy + spread(sc),
              $urandom_range(0, sc), $urandom_range(0, sc));
  endfunction

  // Offer one request and hold it until accepted
  task automatic send(sci_pkg::sci_in_t r);
    if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_q.size() > 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    sci_pkg::sci_in_t r;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: no motion, extremes, touching at one, tangent, misses, overlap
    send(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(MIN_I, MIN_I, MAX_I, MAX_I, MAX_I, MAX_I, MIN_I, MIN_I, MAX_I, MAX_I));
    send(mk(MAX_I, MAX_I, MAX_I, MAX_I, MIN_I, MIN_I, MIN_I, MIN_I, 0, 0));
    send(mk(0, 0, 2 * UNIT, 0, 4 * UNIT, 0, 4 * UNIT, 0, UNIT, UNIT));
    send(mk(0, 0, UNIT, 0, 4 * UNIT, 0, 4 * UNIT, 0, UNIT, UNIT));
    send(mk(0, 0, 4 * UNIT, 0, 4 * UNIT, 0, 4 * UNIT, 0, UNIT, UNIT));
    send(mk(0, 0, 8 * UNIT, 0, 4 * UNIT, 2 * UNIT, 4 * UNIT, 2 * UNIT, UNIT, UNIT));
    send(mk(0, 0, 8 * UNIT, 0, 4 * UNIT, 3 * UNIT, 4 * UNIT, 3 * UNIT, UNIT, UNIT));
    send(mk(0, 0, -UNIT, 0, 4 * UNIT, 0, 4 * UNIT, 0, UNIT, UNIT));
    send(mk(0, 0, 0, 0, 0, 0, UNIT, 0, 3 * UNIT, UNIT));
    send(mk(0, 0, 0, 0, 0, 0, UNIT, 0, UNIT, 3 * UNIT));
    send(mk(0, 0, 4 * UNIT, 0, 2 * UNIT, 0, 2 * UNIT, 0, UNIT, UNIT));
    send(mk(0, 0, 0, 0, 2 * UNIT, 0, 2 * UNIT, 0, UNIT, UNIT));
    send(mk(0, 0, 0, 0, 10 * UNIT, 0, 0, 0, 0, 0));
    send(mk(5, 7, -3, 9, 1, -2, 4, 4, MAX_I, 0));
    send(mk(0, 0, 1, 1, 0, 0, 0, 0, 0, MAX_I));
    drain();

    // Random: mostly plausible pairs, some full-range noise
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= 300 && i < 420);
      if (i == 520) drain();
      if ($urandom_range(0, 9) == 0)
        r = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom);
      else
        r = random_pair();
      send(r);
    end
    quiet = 1'b0;
    drain();
    repeat (30) @(posedge clk);

    $display("covered %0d requests, %0d results, %0d hits, incl. long output hold-off",
             accepted, board.results, board.hits);
    if (board.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
